// ===== rtl/bts_pkg.sv =====
// Shared types, widths and helpers for the bilinear texture sampler.
// No dependencies; imported by the front end, blend, back end, top level, checker and testbench.
`default_nettype none

package bts_pkg;

    // Fixed-point format of the coordinates and blend weights
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 17;
    localparam int SIZE_W    = 7;
    localparam int TXY_W     = 6;
    localparam int TEXEL_W   = 32;
    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 4;

    // Derived arithmetic widths
    localparam int T_W   = COORD_W + SIZE_W;          // u*size + half
    localparam int IDX_W = T_W - FRAC_BITS;           // integer part of t
    localparam int WGT_W = FRAC_BITS + 1;             // weight up to 1.0
    localparam int H_W   = FRAC_BITS + CHAN_W;        // horizontal lerp
    localparam int P_W   = 2 * FRAC_BITS + CHAN_W;    // vertical product
    localparam int PAY_W = (TEXEL_W > 2 * FRAC_BITS) ? TEXEL_W : 2 * FRAC_BITS;

    localparam logic [T_W-1:0]   T_HALF = T_W'(1) << (FRAC_BITS - 1);
    localparam logic [WGT_W-1:0] W_ONE  = WGT_W'(1) << FRAC_BITS;
    localparam logic [P_W-1:0]   P_HALF = P_W'(1) << (2 * FRAC_BITS - 1);

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // Queue depths
    localparam int CMD_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic {
        REG_TEX_WIDTH  = 1'b0,
        REG_TEX_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } seq_state_t;

    typedef struct packed {
        logic [IDX_W-1:0]     lo;
        logic [IDX_W-1:0]     hi;
        logic [FRAC_BITS-1:0] frac;
    } axis_t;

    // Neighbor indices clamped to the edge, plus weight of the upper one.
    // t is the position shifted by half a texel, size is at least 1.
    function automatic axis_t axis_setup(input logic [T_W-1:0] t,
                                         input logic [SIZE_W-1:0] size);
        logic [IDX_W-1:0] i1;
        logic [IDX_W-1:0] i0;
        logic [IDX_W-1:0] last;
        axis_t r;
        i1     = t[T_W-1:FRAC_BITS];
        i0     = (i1 == '0) ? '0 : i1 - IDX_W'(1);
        last   = IDX_W'(size) - IDX_W'(1);
        r.lo   = (i0 > last) ? last : i0;
        r.hi   = (i1 > last) ? last : i1;
        r.frac = t[FRAC_BITS-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bts_ram.sv =====
// Generic single-port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module bts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem_reg[addr] <= wdata;
            end else begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/bts_fifo.sv =====
// Small register FIFO with valid/ready on both sides.
// Depends on nothing; used for the command queue and the result queue.
`default_nettype none

module bts_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bts_front.sv =====
// Front end: accepts transactions, scales coordinates and clamps neighbors,
// builds texel addresses and hands commands to the queue. Uses bts_pkg.
`default_nettype none

module bts_front import bts_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_op,
    input  wire logic [TXY_W-1:0]   s_texel_x,
    input  wire logic [TXY_W-1:0]   s_texel_y,
    input  wire logic [TEXEL_W-1:0] s_texel_rgba,
    input  wire logic [COORD_W-1:0] s_u_coord,
    input  wire logic [COORD_W-1:0] s_v_coord,
    input  wire logic [SIZE_W-1:0]  tex_width,
    input  wire logic [SIZE_W-1:0]  tex_height,
    output logic                    cmd_valid,
    input  wire logic               cmd_ready,
    output logic                    cmd_sample,
    output logic      [AW-1:0]      cmd_a00,
    output logic      [AW-1:0]      cmd_a10,
    output logic      [AW-1:0]      cmd_a01,
    output logic      [AW-1:0]      cmd_a11,
    output logic      [PAY_W-1:0]   cmd_pay
);

    function automatic logic [AW-1:0] texel_addr(input logic [IDX_W-1:0] x,
                                                 input logic [IDX_W-1:0] y);
        return AW'(32'(y) * 32'(MAX_WIDTH) + 32'(x));
    endfunction

    logic [SIZE_W-1:0]  w_eff, h_eff;
    logic               s_acc, in_store, advance;
    logic               fv_reg, fv_next;
    op_t                op_reg;
    logic               keep_reg;
    logic [AW-1:0]      waddr_reg;
    logic [TEXEL_W-1:0] rgba_reg;
    logic [T_W-1:0]     tx_reg, ty_reg;
    logic [SIZE_W-1:0]  w_reg, h_reg;
    axis_t              ax, ay;

    // sizes in use: zero reads as one, oversize as the store limit
    always_comb begin
        w_eff = tex_width;
        if (tex_width == '0) begin
            w_eff = SIZE_W'(1);
        end else if (32'(tex_width) > 32'(MAX_WIDTH)) begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end
        h_eff = tex_height;
        if (tex_height == '0) begin
            h_eff = SIZE_W'(1);
        end else if (32'(tex_height) > 32'(MAX_HEIGHT)) begin
            h_eff = SIZE_W'(MAX_HEIGHT);
        end
    end

    // handshake: stage register drains to the queue, or drops a stray write
    assign s_acc    = s_valid && s_ready;
    assign in_store = (32'(s_texel_x) < 32'(MAX_WIDTH)) &&
                      (32'(s_texel_y) < 32'(MAX_HEIGHT));
    assign advance  = fv_reg && (!keep_reg || cmd_ready);
    assign s_ready  = !fv_reg || advance;

    always_comb begin
        fv_next = fv_reg;
        if (s_acc) begin
            fv_next = 1'b1;
        end else if (advance) begin
            fv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else begin
            fv_reg <= fv_next;
        end
    end

    // stage 1: capture and scale the coordinates
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            op_reg    <= op_t'(s_op);
            keep_reg  <= (op_t'(s_op) == OP_SAMPLE) || in_store;
            waddr_reg <= AW'(32'(s_texel_y) * 32'(MAX_WIDTH) + 32'(s_texel_x));
            rgba_reg  <= s_texel_rgba;
            tx_reg    <= T_W'(s_u_coord) * T_W'(w_eff) + T_HALF;
            ty_reg    <= T_W'(s_v_coord) * T_W'(h_eff) + T_HALF;
            w_reg     <= w_eff;
            h_reg     <= h_eff;
        end
    end

    // stage 2: neighbor clamp and addresses
    assign ax = axis_setup(tx_reg, w_reg);
    assign ay = axis_setup(ty_reg, h_reg);

    assign cmd_valid  = fv_reg && keep_reg;
    assign cmd_sample = (op_reg == OP_SAMPLE);

    always_comb begin
        if (op_reg == OP_SAMPLE) begin
            cmd_a00 = texel_addr(ax.lo, ay.lo);
            cmd_pay = PAY_W'({ay.frac, ax.frac});
        end else begin
            cmd_a00 = waddr_reg;
            cmd_pay = PAY_W'(rgba_reg);
        end
        cmd_a10 = texel_addr(ax.hi, ay.lo);
        cmd_a01 = texel_addr(ax.lo, ay.hi);
        cmd_a11 = texel_addr(ax.hi, ay.hi);
    end

endmodule

`default_nettype wire

// ===== rtl/bts_blend.sv =====
// Three-stage blend pipeline: horizontal lerp, vertical weighting,
// sum and round per channel. Uses bts_pkg.
`default_nettype none

module bts_blend import bts_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    input  wire logic [TEXEL_W-1:0]   c00,
    input  wire logic [TEXEL_W-1:0]   c10,
    input  wire logic [TEXEL_W-1:0]   c01,
    input  wire logic [TEXEL_W-1:0]   c11,
    input  wire logic [FRAC_BITS-1:0] fx,
    input  wire logic [FRAC_BITS-1:0] fy,
    output logic                      out_valid,
    output logic      [TEXEL_W-1:0]   out_rgba
);

    logic [WGT_W-1:0]     wx0, wy0;
    logic [H_W-1:0]       h0_next [NUM_CHAN];
    logic [H_W-1:0]       h1_next [NUM_CHAN];
    logic [H_W-1:0]       h0_reg  [NUM_CHAN];
    logic [H_W-1:0]       h1_reg  [NUM_CHAN];
    logic [FRAC_BITS-1:0] fy_reg;
    logic [P_W-1:0]       p0_next [NUM_CHAN];
    logic [P_W-1:0]       p1_next [NUM_CHAN];
    logic [P_W-1:0]       p0_reg  [NUM_CHAN];
    logic [P_W-1:0]       p1_reg  [NUM_CHAN];
    logic [P_W-1:0]       sum;
    logic [TEXEL_W-1:0]   rgba_next, rgba_reg;
    logic                 v1_reg, v2_reg, v3_reg;

    assign wx0 = W_ONE - WGT_W'(fx);
    assign wy0 = W_ONE - WGT_W'(fy_reg);

    // stage 1: lerp along x for both rows
    always_comb begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            h0_next[ch] = H_W'(wx0) * H_W'(c00[ch*CHAN_W +: CHAN_W]) +
                          H_W'(fx)  * H_W'(c10[ch*CHAN_W +: CHAN_W]);
            h1_next[ch] = H_W'(wx0) * H_W'(c01[ch*CHAN_W +: CHAN_W]) +
                          H_W'(fx)  * H_W'(c11[ch*CHAN_W +: CHAN_W]);
        end
    end

    // stage 2: weight the rows along y
    always_comb begin
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            p0_next[ch] = P_W'(wy0)    * P_W'(h0_reg[ch]);
            p1_next[ch] = P_W'(fy_reg) * P_W'(h1_reg[ch]);
        end
    end

    // stage 3: add, round half up, keep the integer byte
    always_comb begin
        sum = '0;
        for (int ch = 0; ch < NUM_CHAN; ch++) begin
            sum = p0_reg[ch] + p1_reg[ch] + P_HALF;
            rgba_next[ch*CHAN_W +: CHAN_W] = sum[2*FRAC_BITS +: CHAN_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            h0_reg <= h0_next;
            h1_reg <= h1_next;
            fy_reg <= fy;
        end
        if (v1_reg) begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
        end
        if (v2_reg) begin
            rgba_reg <= rgba_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_rgba  = rgba_reg;

endmodule

`default_nettype wire

// ===== rtl/bts_back.sv =====
// Back end: pops commands, writes texels or runs four reads per sample on
// the texel RAM, feeds the blend pipe and queues results. Uses bts_pkg,
// bts_ram, bts_blend and bts_fifo.
`default_nettype none

module bts_back import bts_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire logic               cmd_sample,
    input  wire logic [AW-1:0]      cmd_a00,
    input  wire logic [AW-1:0]      cmd_a10,
    input  wire logic [AW-1:0]      cmd_a01,
    input  wire logic [AW-1:0]      cmd_a11,
    input  wire logic [PAY_W-1:0]   cmd_pay,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output logic      [TEXEL_W-1:0] res_rgba
);

    localparam int CW = $clog2(OUT_DEPTH + 1);

    // read slots within one sample
    localparam logic [1:0] TAP_00 = 2'd0;
    localparam logic [1:0] TAP_10 = 2'd1;
    localparam logic [1:0] TAP_01 = 2'd2;
    localparam logic [1:0] TAP_11 = 2'd3;

    seq_state_t           state_reg, state_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic [AW-1:0]        a10_reg, a01_reg, a11_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;
    logic                 rd_pend_reg;
    logic [1:0]           rd_tag_reg;
    logic [TEXEL_W-1:0]   t00_reg, t10_reg, t01_reg;
    logic [CW-1:0]        inflight_reg, inflight_next;
    logic                 credit, start, res_pop;
    logic                 ram_en, ram_we;
    logic [AW-1:0]        ram_addr;
    logic [TEXEL_W-1:0]   ram_rdata;
    logic                 blend_in_valid, blend_out_valid;
    logic [TEXEL_W-1:0]   blend_rgba;

    // a sample may start only if the result queue has room reserved for it
    assign credit  = (inflight_reg < CW'(OUT_DEPTH));
    assign res_pop = res_valid && res_ready;

    // sequencer: a write is done from the idle state, a sample runs four reads
    always_comb begin
        cmd_ready  = 1'b0;
        ram_en     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = cmd_a00;
        start      = 1'b0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (!cmd_sample) begin
                        cmd_ready = 1'b1;
                        ram_en    = 1'b1;
                        ram_we    = 1'b1;
                    end else if (credit) begin
                        cmd_ready  = 1'b1;
                        ram_en     = 1'b1;
                        start      = 1'b1;
                        state_next = ST_READ;
                        cnt_next   = TAP_10;
                    end
                end
            end
            ST_READ: begin
                ram_en = 1'b1;
                case (cnt_reg)
                    TAP_10:  ram_addr = a10_reg;
                    TAP_01:  ram_addr = a01_reg;
                    default: ram_addr = a11_reg;
                endcase
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == TAP_11) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        inflight_next = inflight_reg + CW'(start) - CW'(res_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= TAP_00;
            rd_pend_reg  <= 1'b0;
            rd_tag_reg   <= TAP_00;
            inflight_reg <= '0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_pend_reg  <= ram_en && !ram_we;
            rd_tag_reg   <= start ? TAP_00 : cnt_reg;
            inflight_reg <= inflight_next;
        end
    end

    // latch the sample's remaining addresses and weights
    always_ff @(posedge aclk) begin
        if (start) begin
            a10_reg <= cmd_a10;
            a01_reg <= cmd_a01;
            a11_reg <= cmd_a11;
            fx_reg  <= cmd_pay[FRAC_BITS-1:0];
            fy_reg  <= cmd_pay[2*FRAC_BITS-1:FRAC_BITS];
        end
    end

    // collect the first three texels; the last one goes straight to the blend
    always_ff @(posedge aclk) begin
        if (rd_pend_reg) begin
            case (rd_tag_reg)
                TAP_00:  t00_reg <= ram_rdata;
                TAP_10:  t10_reg <= ram_rdata;
                TAP_01:  t01_reg <= ram_rdata;
                default: ;
            endcase
        end
    end

    assign blend_in_valid = rd_pend_reg && (rd_tag_reg == TAP_11);

    bts_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (DEPTH)
    ) u_tex_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cmd_pay[TEXEL_W-1:0]),
        .rdata (ram_rdata)
    );

    bts_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (blend_in_valid),
        .c00       (t00_reg),
        .c10       (t10_reg),
        .c01       (t01_reg),
        .c11       (ram_rdata),
        .fx        (fx_reg),
        .fy        (fy_reg),
        .out_valid (blend_out_valid),
        .out_rgba  (blend_rgba)
    );

    // result queue, never full when a result arrives thanks to the credit
    bts_fifo #(
        .WIDTH (TEXEL_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (blend_out_valid),
        .in_ready  (),
        .in_data   (blend_rgba),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_data  (res_rgba)
    );

endmodule

`default_nettype wire

// ===== rtl/bilinear_texture_sampler_unit.sv =====
// Bilinear texture sampler, top level: config registers, front end, command queue, back end.
// Texel writes go at one per cycle unless the back end is busy with a sample; a sample is
// four reads, one per texel, on the single-port texel RAM, during which no command is taken.
// Reset (aresetn, synchronous, active low) clears control state and sets both sizes to 64;
// the texel RAM is not cleared and holds garbage until written. Uses bts_pkg and submodules.
`default_nettype none

module bilinear_texture_sampler_unit import bts_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // input transactions
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_op,
    input  wire logic [TXY_W-1:0]      s_texel_x,
    input  wire logic [TXY_W-1:0]      s_texel_y,
    input  wire logic [TEXEL_W-1:0]    s_texel_rgba,
    input  wire logic [COORD_W-1:0]    s_u_coord,
    input  wire logic [COORD_W-1:0]    s_v_coord,
    // results
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [CHAN_W-1:0]     m_red,
    output logic      [CHAN_W-1:0]     m_green,
    output logic      [CHAN_W-1:0]     m_blue,
    output logic      [CHAN_W-1:0]     m_alpha
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMD_W = 1 + 4 * AW + PAY_W;

    logic [SIZE_W-1:0]  tex_width_reg, tex_height_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;
    logic               f_valid, f_ready, f_sample;
    logic [AW-1:0]      f_a00, f_a10, f_a01, f_a11;
    logic [PAY_W-1:0]   f_pay;
    logic [CMD_W-1:0]   f_cmd, b_cmd;
    logic               b_valid, b_ready;
    logic [TEXEL_W-1:0] res_rgba;

    // configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tex_width_reg  <= SIZE_RESET;
            tex_height_reg <= SIZE_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_TEX_WIDTH:  tex_width_reg  <= pwdata[SIZE_W-1:0];
                REG_TEX_HEIGHT: tex_height_reg <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_TEX_WIDTH:  prdata = APB_DATA_W'(tex_width_reg);
            REG_TEX_HEIGHT: prdata = APB_DATA_W'(tex_height_reg);
            default:        prdata = '0;
        endcase
    end

    bts_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_texel_x    (s_texel_x),
        .s_texel_y    (s_texel_y),
        .s_texel_rgba (s_texel_rgba),
        .s_u_coord    (s_u_coord),
        .s_v_coord    (s_v_coord),
        .tex_width    (tex_width_reg),
        .tex_height   (tex_height_reg),
        .cmd_valid    (f_valid),
        .cmd_ready    (f_ready),
        .cmd_sample   (f_sample),
        .cmd_a00      (f_a00),
        .cmd_a10      (f_a10),
        .cmd_a01      (f_a01),
        .cmd_a11      (f_a11),
        .cmd_pay      (f_pay)
    );

    // command queue between front and back
    assign f_cmd = {f_sample, f_a00, f_a10, f_a01, f_a11, f_pay};

    bts_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_cmd),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_cmd)
    );

    bts_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (b_valid),
        .cmd_ready  (b_ready),
        .cmd_sample (b_cmd[CMD_W-1]),
        .cmd_a00    (b_cmd[PAY_W + 3*AW +: AW]),
        .cmd_a10    (b_cmd[PAY_W + 2*AW +: AW]),
        .cmd_a01    (b_cmd[PAY_W + AW +: AW]),
        .cmd_a11    (b_cmd[PAY_W +: AW]),
        .cmd_pay    (b_cmd[PAY_W-1:0]),
        .res_valid  (m_valid),
        .res_ready  (m_ready),
        .res_rgba   (res_rgba)
    );

    assign m_red   = res_rgba[0*CHAN_W +: CHAN_W];
    assign m_green = res_rgba[1*CHAN_W +: CHAN_W];
    assign m_blue  = res_rgba[2*CHAN_W +: CHAN_W];
    assign m_alpha = res_rgba[3*CHAN_W +: CHAN_W];

endmodule

`default_nettype wire

// ===== rtl/bts_checker.sv =====
// Port-level checks for the bilinear texture sampler, bound to the top level.
// Uses bts_pkg for port widths.
`default_nettype none

module bts_checker import bts_pkg::*; (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  psel,
    input wire logic                  penable,
    input wire logic                  pwrite,
    input wire logic [APB_ADDR_W-1:0] paddr,
    input wire logic [APB_DATA_W-1:0] pwdata,
    input wire logic [APB_DATA_W-1:0] prdata,
    input wire logic                  pready,
    input wire logic                  s_valid,
    input wire logic                  s_ready,
    input wire logic                  s_op,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [CHAN_W-1:0]     m_red,
    input wire logic [CHAN_W-1:0]     m_green,
    input wire logic [CHAN_W-1:0]     m_blue,
    input wire logic [CHAN_W-1:0]     m_alpha
);

    // samples taken but not yet answered
    logic [7:0] pend_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + 8'(s_valid && s_ready && (op_t'(s_op) == OP_SAMPLE))
                                 - 8'(m_valid && m_ready);
        end
    end

    // no result is left over after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
                                && $stable(m_blue) && $stable(m_alpha))
        else $error("stalled result changed or dropped");

    // every result answers an earlier sample transaction
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != '0)
        else $error("result without a pending sample");

    // a written size register reads back
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready
        |=> !$stable(paddr) || prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0]))
        else $error("size register readback mismatch");

endmodule

bind bilinear_texture_sampler_unit bts_checker u_chk (.*);

`default_nettype wire

// ===== bench/tb_bilinear_texture_sampler_unit.sv =====
// Self-checking testbench for bilinear_texture_sampler_unit: texel loads, filtered samples
// and the size registers. Depends on bts_pkg and the RTL of the sampler only.
// A shadow texture predicts each filtered pixel; results are checked in order.

module tb_bilinear_texture_sampler_unit;
    import bts_pkg::*;

    localparam int STORE_W      = DEF_MAX_WIDTH;
    localparam int STORE_H      = DEF_MAX_HEIGHT;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 32;
    localparam int RANDOM_ITEMS = 1500;
    localparam longint unsigned FRAC_ONE = 64'd1 << FRAC_BITS;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } pixel_t;

    // Receiver backpressure patterns
    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_op;
    logic [TXY_W-1:0]      s_texel_x;
    logic [TXY_W-1:0]      s_texel_y;
    logic [TEXEL_W-1:0]    s_texel_rgba;
    logic [COORD_W-1:0]    s_u_coord;
    logic [COORD_W-1:0]    s_v_coord;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CHAN_W-1:0]     m_red;
    logic [CHAN_W-1:0]     m_green;
    logic [CHAN_W-1:0]     m_blue;
    logic [CHAN_W-1:0]     m_alpha;

    // Shadow texture, size registers and the queue of pixels still to come
    logic [TEXEL_W-1:0] texel_shadow [STORE_W*STORE_H];
    bit                 texel_loaded [STORE_W*STORE_H];
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    pixel_t             pending_pixels[$];

    int       errors          = 0;
    int       samples_sent    = 0;
    int       loads_sent      = 0;
    int       pixels_checked  = 0;
    int       size_settings   = 0;
    int       random_items    = 0;
    longint   cycles          = 0;
    bit       gaps_on         = 1'b0;
    int       burst_left      = 0;
    rx_mode_t rx_mode         = RX_ALWAYS;
    int       rx_left         = 0;

    bilinear_texture_sampler_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_texel_x    (s_texel_x),
        .s_texel_y    (s_texel_y),
        .s_texel_rgba (s_texel_rgba),
        .s_u_coord    (s_u_coord),
        .s_v_coord    (s_v_coord),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_alpha      (m_alpha)
    );

    always #4 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("bilinear_texture_sampler_unit verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- prediction

    // Register value as the filter uses it: zero acts as one, oversize saturates
    function automatic int size_in_use(input logic [SIZE_W-1:0] r, input int maxv);
        if (r == '0)
            return 1;
        if (int'(r) > maxv)
            return maxv;
        return int'(r);
    endfunction

    // Floor and floor+1 texel along one axis, edge clamped, plus weight of the upper one
    function automatic void edge_neighbors(input logic [COORD_W-1:0] coord, input int size,
                                           output int lo, output int hi,
                                           output longint unsigned frac);
        longint unsigned t;
        longint unsigned i0;
        longint unsigned i1;
        longint unsigned last;
        t    = 64'(coord) * 64'(size) + (FRAC_ONE >> 1);
        i1   = t >> FRAC_BITS;
        i0   = (i1 == 0) ? 64'd0 : i1 - 64'd1;
        last = 64'(size - 1);
        if (i0 > last)
            i0 = last;
        if (i1 > last)
            i1 = last;
        lo   = int'(i0);
        hi   = int'(i1);
        frac = t & (FRAC_ONE - 64'd1);
    endfunction

    // Bilinear blend of the four neighbors, each channel rounded half up
    function automatic pixel_t filter_pixel(input logic [COORD_W-1:0] u,
                                            input logic [COORD_W-1:0] v);
        int x0, x1, y0, y1, ch;
        longint unsigned fx, fy, wx0, wy0, a, b, c, d, acc;
        logic [TEXEL_W-1:0] c00, c10, c01, c11;
        logic [CHAN_W-1:0] chan [NUM_CHAN];
        pixel_t px;
        edge_neighbors(u, size_in_use(width_reg, STORE_W), x0, x1, fx);
        edge_neighbors(v, size_in_use(height_reg, STORE_H), y0, y1, fy);
        c00 = texel_shadow[y0*STORE_W + x0];
        c10 = texel_shadow[y0*STORE_W + x1];
        c01 = texel_shadow[y1*STORE_W + x0];
        c11 = texel_shadow[y1*STORE_W + x1];
        wx0 = FRAC_ONE - fx;
        wy0 = FRAC_ONE - fy;
        for (ch = 0; ch < NUM_CHAN; ch++) begin
            a   = 64'(c00[8*ch +: 8]);
            b   = 64'(c10[8*ch +: 8]);
            c   = 64'(c01[8*ch +: 8]);
            d   = 64'(c11[8*ch +: 8]);
            acc = wx0*wy0*a + fx*wy0*b + wx0*fy*c + fx*fy*d;
            acc = (acc + (64'd1 << (2*FRAC_BITS - 1))) >> (2*FRAC_BITS);
            chan[ch] = acc[CHAN_W-1:0];
        end
        px.red   = chan[0];
        px.green = chan[1];
        px.blue  = chan[2];
        px.alpha = chan[3];
        return px;
    endfunction

    // ---------------------------------------------------------------- result side

    // Backpressure: the pattern is redrawn whenever rx_left runs out
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 300);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_ALWAYS:   m_ready <= 1'b1;
            RX_RANDOM:   m_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_ready <= (cycles % 5 != 4);
            default:     m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic report_error(input string what, input logic [31:0] exp_val,
                                input logic [31:0] act_val);
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_val, act_val);
    endtask

    // Each result transaction against the oldest predicted pixel
    always @(posedge aclk) begin
        pixel_t exp_px;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready) begin
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction %h %h %h %h", $time,
                         m_red, m_green, m_blue, m_alpha);
            end else begin
                exp_px = pending_pixels.pop_front();
                pixels_checked++;
                if (m_red !== exp_px.red)
                    report_error("red", 32'(exp_px.red), 32'(m_red));
                if (m_green !== exp_px.green)
                    report_error("green", 32'(exp_px.green), 32'(m_green));
                if (m_blue !== exp_px.blue)
                    report_error("blue", 32'(exp_px.blue), 32'(m_blue));
                if (m_alpha !== exp_px.alpha)
                    report_error("alpha", 32'(exp_px.alpha), 32'(m_alpha));
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic logic [COORD_W-1:0] rand_coord();
        int pick;
        pick = $urandom_range(0, 19);
        case (pick)
            0:       return '0;
            1:       return COORD_W'(FRAC_ONE);
            2:       return '1;
            3, 4, 5: return COORD_W'($urandom_range(65537, 131071));
            default: return COORD_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // One input transaction, with bursty gaps; updates the shadow on acceptance
    task automatic push_transaction(input op_t op, input logic [TXY_W-1:0] tx,
                                    input logic [TXY_W-1:0] ty,
                                    input logic [TEXEL_W-1:0] rgba,
                                    input logic [COORD_W-1:0] u,
                                    input logic [COORD_W-1:0] v);
        int gap;
        @(negedge aclk);
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        s_valid      <= 1'b1;
        s_op         <= op;
        s_texel_x    <= tx;
        s_texel_y    <= ty;
        s_texel_rgba <= rgba;
        s_u_coord    <= u;
        s_v_coord    <= v;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (op == OP_WRITE) begin
            texel_shadow[int'(ty)*STORE_W + int'(tx)] = rgba;
            texel_loaded[int'(ty)*STORE_W + int'(tx)] = 1'b1;
            loads_sent++;
        end else begin
            pending_pixels.push_back(filter_pixel(u, v));
            samples_sent++;
        end
    endtask

    task automatic load_texel(input int tx, input int ty, input logic [TEXEL_W-1:0] rgba);
        push_transaction(OP_WRITE, TXY_W'(tx), TXY_W'(ty), rgba,
                         COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // Loads any neighbor that was never written, then samples
    task automatic sample_texture(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
        int xs [2];
        int ys [2];
        int i, j;
        longint unsigned fx, fy;
        edge_neighbors(u, size_in_use(width_reg, STORE_W), xs[0], xs[1], fx);
        edge_neighbors(v, size_in_use(height_reg, STORE_H), ys[0], ys[1], fy);
        for (i = 0; i < 2; i++)
            for (j = 0; j < 2; j++)
                if (!texel_loaded[ys[j]*STORE_W + xs[i]])
                    load_texel(xs[i], ys[j], $urandom);
        push_transaction(OP_SAMPLE, TXY_W'($urandom), TXY_W'($urandom), $urandom, u, v);
    endtask

    // Sender stops and everything drains, including loads still in flight
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- configuration

    task automatic apb_access(input bit is_write, input reg_idx_t idx,
                              input logic [APB_DATA_W-1:0] data,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= APB_ADDR_W'(idx) << 2;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input reg_idx_t idx, input logic [SIZE_W-1:0] exp_val);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== APB_DATA_W'(exp_val))
            report_error(idx == REG_TEX_WIDTH ? "tex_width readback" : "tex_height readback",
                         32'(exp_val), 32'(rd));
    endtask

    // Write with junk above the register bits, then read back; block must be idle
    task automatic set_size(input reg_idx_t idx, input logic [SIZE_W-1:0] val);
        logic [APB_DATA_W-1:0] rd;
        logic [APB_DATA_W-1:0] data;
        data = $urandom;
        data[SIZE_W-1:0] = val;
        apb_access(1'b1, idx, data, rd);
        if (idx == REG_TEX_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        size_settings++;
        check_reg(idx, val);
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return '0;
            1:       return SIZE_W'(1);
            2:       return SIZE_W'(64);
            3:       return SIZE_W'($urandom_range(65, 127));
            default: return SIZE_W'($urandom_range(1, 64));
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        check_reg(REG_TEX_WIDTH, SIZE_RESET);
        check_reg(REG_TEX_HEIGHT, SIZE_RESET);
    endtask

    // Corners, full-scale texels and coordinates at and past 1.0 on the 64x64 default
    task automatic test_directed_corners();
        gaps_on = 1'b0;
        load_texel(0, 0, 32'h0000_0000);
        load_texel(63, 63, 32'hFFFF_FFFF);
        load_texel(63, 0, 32'h80FF_007F);
        load_texel(0, 63, 32'h0102_0304);
        sample_texture('0, '0);
        sample_texture(COORD_W'(FRAC_ONE), COORD_W'(FRAC_ONE));
        sample_texture('1, '1);
        sample_texture(COORD_W'(FRAC_ONE), '0);
        sample_texture('0, COORD_W'(FRAC_ONE));
        sample_texture(17'd32768, 17'd32768);
        sample_texture(17'd1024, 17'd1024);
        sample_texture(17'd1536, 17'd1536);
        wait_idle();
    endtask

    // Size of one, zero treated as one, oversize saturating, thin strips
    task automatic test_size_registers();
        logic [SIZE_W-1:0] widths  [5] = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd64};
        logic [SIZE_W-1:0] heights [5] = '{7'd1, 7'd0, 7'd127, 7'd2,  7'd1};
        int k;
        for (k = 0; k < 5; k++) begin
            set_size(REG_TEX_WIDTH, widths[k]);
            set_size(REG_TEX_HEIGHT, heights[k]);
            sample_texture(rand_coord(), rand_coord());
            sample_texture(rand_coord(), rand_coord());
            wait_idle();
        end
    endtask

    // Phases of mixed loads and samples under random sizes and idling;
    // the budget counts every transaction sent, neighbor loads included
    task automatic test_random_traffic();
        int n;
        int base;
        base = loads_sent + samples_sent;
        while (random_items < RANDOM_ITEMS) begin
            set_size(REG_TEX_WIDTH, pick_size());
            set_size(REG_TEX_HEIGHT, pick_size());
            gaps_on = ($urandom_range(0, 3) != 0);
            for (n = 0; n < 150 && random_items < RANDOM_ITEMS; n++) begin
                if ($urandom_range(0, 3) == 0)
                    load_texel($urandom_range(0, STORE_W-1), $urandom_range(0, STORE_H-1),
                               $urandom);
                else
                    sample_texture(rand_coord(), rand_coord());
                random_items = loads_sent + samples_sent - base;
            end
            wait_idle();
        end
    endtask

    // Sender holds off mid-stream until every pixel is back, then resumes
    task automatic test_drain_pause();
        int n;
        set_size(REG_TEX_WIDTH, SIZE_W'(64));
        set_size(REG_TEX_HEIGHT, SIZE_W'(64));
        gaps_on = 1'b0;
        for (n = 0; n < 20; n++)
            sample_texture(rand_coord(), rand_coord());
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        for (n = 0; n < 20; n++)
            sample_texture(rand_coord(), rand_coord());
        wait_idle();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_op         = OP_WRITE;
        s_texel_x    = '0;
        s_texel_y    = '0;
        s_texel_rgba = '0;
        s_u_coord    = '0;
        s_v_coord    = '0;
        width_reg    = SIZE_RESET;
        height_reg   = SIZE_RESET;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_directed_corners();
        test_size_registers();
        test_random_traffic();
        test_drain_pause();

        wait_idle();
        $display("Covered %0d texel loads and %0d samples over %0d size register writes;",
                 loads_sent, samples_sent, size_settings);
        $display("%0d filtered pixels compared, %0d errors.", pixels_checked, errors);
        if (errors == 0 && pending_pixels.size() == 0)
            $display("bilinear_texture_sampler_unit verification clean");
        else
            $display("bilinear_texture_sampler_unit verification failed");
        $finish;
    end

endmodule
